// ===== rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        CASE_NONQUAD = 2'd0,
        CASE_NOREAL  = 2'd1,
        CASE_DOUBLE  = 2'd2,
        CASE_TWO     = 2'd3
    } root_case_t;

endpackage

// ===== rtl/quadratic_root_solver.sv =====
// Throughput: one equation per cycle while the output is not stalled; the
// square root takes one root bit per stage and the divider's three lanes one
// quotient bit per stage, all fully pipelined. The default format is 32-bit Q16.16.
// A stalled output beat holds the whole pipeline. Reset (rst_n low, async)
// clears all valid bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Discriminant, floor square root, both real roots and the critical point of
// a*x^2 + b*x + c = 0 in signed fixed point, with saturation and case status.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // coef_a, coef_b, coef_c
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // root_case, root_plus, root_minus, vertex_x, saturated
    output logic [((3*COEF_WIDTH+10)/8)*8-1:0]     m_tdata
);
    import qrs_pkg::*;

    localparam int W      = COEF_WIDTH;
    localparam int OUT_TW = ((3*W+10)/8)*8;
    localparam int H      = (W+1)/2;
    localparam int HW     = W - H;
    localparam int PW     = 2*W;
    localparam int DW     = 2*W + 1;
    localparam int SW     = W + 1;
    localparam int NW     = W + 2;
    localparam int NMW    = W + 1;
    localparam int QW     = NMW + FRAC_BITS;
    localparam int SQ_SIDE = 5 + 2*W;
    localparam int DV_SIDE = 6;

    logic ce;
    logic out_valid_reg;
    logic [OUT_TW-1:0] out_data_reg;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // stage 0: split signs and magnitudes
    logic [W-1:0] a_raw, b_raw, c_raw;
    logic         v0_reg, a_neg0_reg, b_neg0_reg, c_neg0_reg;
    logic [W-1:0] a_mag0_reg, b_mag0_reg, c_mag0_reg;

    assign a_raw = s_tdata[W-1:0];
    assign b_raw = s_tdata[2*W-1:W];
    assign c_raw = s_tdata[3*W-1:2*W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (ce)
        begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_neg0_reg <= a_raw[W-1];
            b_neg0_reg <= b_raw[W-1];
            c_neg0_reg <= c_raw[W-1];
            a_mag0_reg <= a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
            b_mag0_reg <= b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;
            c_mag0_reg <= c_raw[W-1] ? (~c_raw + 1'b1) : c_raw;
        end
    end

    // stage 1: partial products of b*b and a*c
    logic          v1_reg, a_neg1_reg, b_neg1_reg, c_neg1_reg;
    logic [W-1:0]  a_mag1_reg, b_mag1_reg;
    logic [2*H-1:0]  bb_ll_reg, ac_ll_reg;
    logic [H+HW-1:0] bb_lh_reg, ac_lh_reg, ac_hl_reg;
    logic [2*HW-1:0] bb_hh_reg, ac_hh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_neg1_reg <= a_neg0_reg;
            b_neg1_reg <= b_neg0_reg;
            c_neg1_reg <= c_neg0_reg;
            a_mag1_reg <= a_mag0_reg;
            b_mag1_reg <= b_mag0_reg;
            bb_ll_reg  <= b_mag0_reg[H-1:0] * b_mag0_reg[H-1:0];
            bb_lh_reg  <= b_mag0_reg[H-1:0] * b_mag0_reg[W-1:H];
            bb_hh_reg  <= b_mag0_reg[W-1:H] * b_mag0_reg[W-1:H];
            ac_ll_reg  <= a_mag0_reg[H-1:0] * c_mag0_reg[H-1:0];
            ac_lh_reg  <= a_mag0_reg[H-1:0] * c_mag0_reg[W-1:H];
            ac_hl_reg  <= a_mag0_reg[W-1:H] * c_mag0_reg[H-1:0];
            ac_hh_reg  <= a_mag0_reg[W-1:H] * c_mag0_reg[W-1:H];
        end
    end

    // stage 2: sum the partial products
    logic          v2_reg, a_neg2_reg, b_neg2_reg, c_neg2_reg;
    logic [W-1:0]  a_mag2_reg, b_mag2_reg;
    logic [PW-1:0] sq2_reg, ac2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (ce)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_neg2_reg <= a_neg1_reg;
            b_neg2_reg <= b_neg1_reg;
            c_neg2_reg <= c_neg1_reg;
            a_mag2_reg <= a_mag1_reg;
            b_mag2_reg <= b_mag1_reg;
            sq2_reg <= (PW'(bb_hh_reg) << (2*H)) + (PW'(bb_lh_reg) << (H+1))
                       + PW'(bb_ll_reg);
            ac2_reg <= (PW'(ac_hh_reg) << (2*H)) + (PW'(ac_lh_reg) << H)
                       + (PW'(ac_hl_reg) << H) + PW'(ac_ll_reg);
        end
    end

    // stage 3: discriminant magnitude and sign
    logic [DW-1:0] sq_ext, fac_ext;
    logic          v3_reg, a_neg3_reg, b_neg3_reg, d_neg3_reg, d_zero3_reg, a_zero3_reg;
    logic [W-1:0]  a_mag3_reg, b_mag3_reg;
    logic [DW-1:0] disc3_reg;
    logic [DW-1:0] disc_next;
    logic          d_neg_next;

    assign sq_ext  = DW'(sq2_reg);
    assign fac_ext = {ac2_reg, 1'b0} << 1;

    always_comb
    begin
        d_neg_next = 1'b0;
        if (a_neg2_reg != c_neg2_reg)
        begin
            disc_next = sq_ext + fac_ext;
        end
        else if (sq_ext < fac_ext)
        begin
            d_neg_next = 1'b1;
            disc_next  = fac_ext - sq_ext;
        end
        else
        begin
            disc_next = sq_ext - fac_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (ce)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_neg3_reg  <= a_neg2_reg;
            b_neg3_reg  <= b_neg2_reg;
            a_mag3_reg  <= a_mag2_reg;
            b_mag3_reg  <= b_mag2_reg;
            a_zero3_reg <= (a_mag2_reg == '0);
            d_neg3_reg  <= d_neg_next;
            d_zero3_reg <= (disc_next == '0);
            disc3_reg   <= disc_next;
        end
    end

    // square root
    logic               sq_valid;
    logic [SW-1:0]      sq_root;
    logic [SQ_SIDE-1:0] sq_side;

    qrs_isqrt #(
        .IN_W   (DW),
        .ROOT_W (SW),
        .SIDE_W (SQ_SIDE)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v3_reg),
        .in_rad    (disc3_reg),
        .in_side   ({a_zero3_reg, a_neg3_reg, b_neg3_reg, d_neg3_reg, d_zero3_reg,
                     a_mag3_reg, b_mag3_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // stage 4: signed numerators -b, -b + s, -b - s
    logic          s4_a_zero, s4_a_neg, s4_b_neg, s4_d_neg, s4_d_zero;
    logic [W-1:0]  s4_a_mag, s4_b_mag;
    logic [NW-1:0] nb, np, nm;
    logic          v4_reg;
    logic [3*NMW-1:0] num4_reg;
    logic [W:0]       den4_reg;
    logic [DV_SIDE-1:0] side4_reg;

    assign {s4_a_zero, s4_a_neg, s4_b_neg, s4_d_neg, s4_d_zero, s4_a_mag, s4_b_mag} = sq_side;

    always_comb
    begin
        nb = s4_b_neg ? NW'(s4_b_mag) : (NW'(0) - NW'(s4_b_mag));
        np = nb + NW'(sq_root);
        nm = nb - NW'(sq_root);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (ce)
        begin
            v4_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            num4_reg[0*NMW +: NMW] <= np[NW-1] ? NMW'(-np) : np[NMW-1:0];
            num4_reg[1*NMW +: NMW] <= nm[NW-1] ? NMW'(-nm) : nm[NMW-1:0];
            num4_reg[2*NMW +: NMW] <= nb[NW-1] ? NMW'(-nb) : nb[NMW-1:0];
            den4_reg  <= {s4_a_mag, 1'b0};
            // quotient signs per lane: plus, minus, vertex
            side4_reg <= {s4_a_zero, s4_d_neg, s4_d_zero,
                          nb[NW-1] ^ s4_a_neg, nm[NW-1] ^ s4_a_neg, np[NW-1] ^ s4_a_neg};
        end
    end

    // dividers
    logic               dv_valid;
    logic [3*QW-1:0]    dv_quot;
    logic [DV_SIDE-1:0] dv_side;

    qrs_div #(
        .NUM_W  (NMW),
        .DEN_W  (W+1),
        .FRAC_W (FRAC_BITS),
        .LANES  (3),
        .SIDE_W (DV_SIDE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (den4_reg),
        .in_side   (side4_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // output stage: saturate, apply sign, select by case
    logic [W-1:0] lane_val [3];
    logic [2:0]   lane_sat;
    logic         o_a_zero, o_d_neg, o_d_zero;
    root_case_t   o_case;
    logic [W-1:0] o_plus, o_minus, o_vertex;
    logic         o_sat;

    assign {o_a_zero, o_d_neg, o_d_zero} = dv_side[5:3];

    always_comb
    begin
        logic [QW-1:0] q;
        logic [QW-1:0] lim;
        logic [W-1:0]  mag;
        for (int j = 0; j < 3; j++)
        begin
            q   = dv_quot[j*QW +: QW];
            lim = dv_side[j] ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - 1'b1);
            lane_sat[j] = (q > lim);
            mag = lane_sat[j] ? lim[W-1:0] : q[W-1:0];
            lane_val[j] = dv_side[j] ? (~mag + 1'b1) : mag;
        end
    end

    always_comb
    begin
        o_plus   = '0;
        o_minus  = '0;
        o_vertex = '0;
        o_sat    = 1'b0;
        if (o_a_zero)
        begin
            o_case = CASE_NONQUAD;
        end
        else if (o_d_neg)
        begin
            o_case   = CASE_NOREAL;
            o_vertex = lane_val[2];
            o_sat    = lane_sat[2];
        end
        else
        begin
            o_case   = o_d_zero ? CASE_DOUBLE : CASE_TWO;
            o_plus   = lane_val[0];
            o_minus  = lane_val[1];
            o_vertex = lane_val[2];
            o_sat    = |lane_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_data_reg <= OUT_TW'({o_sat, o_vertex, o_minus, o_plus, o_case});
        end
    end

    // checks
    a_nonquad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == CASE_NONQUAD) |->
            (m_tdata[3*W+2:2] == '0))
        else $error("non-quadratic result carries nonzero payload");

    a_noreal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == CASE_NOREAL) |->
            (m_tdata[2*W+1:2] == '0))
        else $error("no-real-root result carries roots");

    a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == CASE_DOUBLE) |->
            (m_tdata[W+1:2] == m_tdata[2*W+1:W+2] && m_tdata[W+1:2] == m_tdata[3*W+1:2*W+2]))
        else $error("double root differs from vertex");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

// ===== rtl/qrs_isqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module qrs_isqrt #(
    parameter int IN_W   = 65,
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int PAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic              valid_reg [ROOT_W];
    logic [PAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              valid_prev;
        logic [PAD_W-1:0]  rad_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [PAD_W-1:0]  rad_next;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rad_prev   = {{(PAD_W-IN_W){1'b0}}, in_rad};
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign side_prev  = in_side;
        end
        else begin : g_next
            assign valid_prev = valid_reg[k-1];
            assign rad_prev   = rad_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign side_prev  = side_reg[k-1];
        end

        always_comb
        begin
            rem_sh    = {rem_prev[REM_W-3:0], rad_prev[PAD_W-1 -: 2]};
            trial     = {1'b0, root_prev, 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_prev[ROOT_W-2:0], ge};
            rad_next  = {rad_prev[PAD_W-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== rtl/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, several numerator lanes over one shared
// divisor, one quotient bit per stage; the numerator is scaled by 2^FRAC_W.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NUM_W  = 33,
    parameter int DEN_W  = 33,
    parameter int FRAC_W = 16,
    parameter int LANES  = 3,
    parameter int SIDE_W = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 ce,
    input  logic                                 in_valid,
    input  logic [LANES*NUM_W-1:0]               in_num,
    input  logic [DEN_W-1:0]                     in_den,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic [LANES*(NUM_W+FRAC_W)-1:0]      out_quot,
    output logic [SIDE_W-1:0]                    out_side
);
    localparam int QW = NUM_W + FRAC_W;

    logic              valid_reg [QW];
    logic [DEN_W-1:0]  den_reg   [QW];
    logic [SIDE_W-1:0] side_reg  [QW];
    logic [QW-1:0]     dvd_reg   [QW][LANES];
    logic [DEN_W-1:0]  rem_reg   [QW][LANES];
    logic [QW-1:0]     quot_reg  [QW][LANES];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic              valid_prev;
        logic [DEN_W-1:0]  den_prev;
        logic [SIDE_W-1:0] side_prev;

        if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign den_prev   = in_den;
            assign side_prev  = in_side;
        end
        else begin : g_next
            assign valid_prev = valid_reg[k-1];
            assign den_prev   = den_reg[k-1];
            assign side_prev  = side_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ce)
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end

        for (genvar j = 0; j < LANES; j++) begin : g_lane
            logic [QW-1:0]    dvd_prev;
            logic [DEN_W-1:0] rem_prev;
            logic [QW-1:0]    quot_prev;
            logic [DEN_W:0]   rem_sh;
            logic [DEN_W:0]   rem_sub;
            logic             ge;

            if (k == 0) begin : g_first
                assign dvd_prev  = {in_num[j*NUM_W +: NUM_W], {FRAC_W{1'b0}}};
                assign rem_prev  = '0;
                assign quot_prev = '0;
            end
            else begin : g_next
                assign dvd_prev  = dvd_reg[k-1][j];
                assign rem_prev  = rem_reg[k-1][j];
                assign quot_prev = quot_reg[k-1][j];
            end

            always_comb
            begin
                rem_sh  = {rem_prev, dvd_prev[QW-1]};
                rem_sub = rem_sh - {1'b0, den_prev};
                ge      = (rem_sh >= {1'b0, den_prev});
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    dvd_reg[k][j]  <= {dvd_prev[QW-2:0], 1'b0};
                    rem_reg[k][j]  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                    quot_reg[k][j] <= {quot_prev[QW-2:0], ge};
                end
            end
        end
    end

    for (genvar j = 0; j < LANES; j++) begin : g_out
        assign out_quot[j*QW +: QW] = quot_reg[QW-1][j];
    end

    assign out_valid = valid_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
